// File: hw/rtl/pfb_pkg.sv
// plane frame builder: shared types and constants
// used by pfb_unit, pfb_out and plane_frame_builder_core; no dependencies
package pfb_pkg;

	localparam int DEF_INPUT_FRAC_BITS = 16;
	localparam int COMP_W = 47;
	localparam logic signed [63:0] Q30_ONE = 64'sd1 <<< 30;
	localparam logic signed [63:0] COMP_MAX = (64'sd1 <<< 46) - 64'sd1;
	localparam logic signed [63:0] COMP_MIN = -(64'sd1 <<< 46);

	typedef enum logic [1:0] {
		KIND_ORIGIN,
		KIND_XAXIS,
		KIND_YAXIS,
		KIND_NORMAL
	} kind_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] z;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] x;
	} vec47_t;

	typedef struct packed {
		logic   bad;
		vec47_t org;
		vec47_t xa;
		vec47_t ya;
		vec47_t nu;
	} frame_t;

endpackage

// File: hw/rtl/pfb_unit.sv
// pfb_unit: pipelined vector normalizer, q30 unit vector from a 3-vector
// range scaling, squares, bit-serial square root stages, restoring divide stages
// depends on pfb_pkg
module pfb_unit import pfb_pkg::*; #(
	parameter int PW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [32:0] c [3],
	input  logic [PW-1:0]      in_pay,
	output logic               out_valid,
	output logic signed [31:0] u [3],
	output logic [PW-1:0]      out_pay
);

	localparam int RB = 31;
	localparam int QB = 31;
	localparam int LAT = 4 + RB + 1 + QB + 1;

	logic [31:0] mag_s1 [3];
	logic        neg_s1 [3];
	logic [29:0] m_s2 [3];
	logic        neg_s2 [3];
	logic [59:0] sq_s3 [3];
	logic [29:0] m_s3 [3];
	logic        neg_s3 [3];

	logic [63:0] srem_s [RB+1];
	logic [30:0] sroot_s [RB+1];
	logic [29:0] sm_s [RB+1][3];
	logic        sneg_s [RB+1][3];

	logic [63:0] drem_s [QB+1][3];
	logic [30:0] dq_s [QB+1][3];
	logic [30:0] dlen_s [QB+1];
	logic        dneg_s [QB+1][3];

	logic signed [31:0] uo_s [3];
	logic               vld_s [LAT];
	logic [PW-1:0]      pay_s [LAT];

	logic [31:0] mx_b;
	logic [4:0]  pos_b;
	logic [31:0] shf_b [3];

	always_comb begin
		mx_b = mag_s1[0];
		if (mag_s1[1] > mx_b) mx_b = mag_s1[1];
		if (mag_s1[2] > mx_b) mx_b = mag_s1[2];
		pos_b = '0;
		for (int i = 0; i < 32; i++) begin
			if (mx_b[i]) pos_b = 5'(i);
		end
		for (int i = 0; i < 3; i++) begin
			if (pos_b >= 5'd29) shf_b[i] = mag_s1[i] >> (pos_b - 5'd29);
			else shf_b[i] = mag_s1[i] << (5'd29 - pos_b);
		end
	end

	// scaling, squares, sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= c[i][32];
				mag_s1[i] <= c[i][32] ? 32'(-c[i]) : c[i][31:0];
				m_s2[i] <= shf_b[i][29:0];
				neg_s2[i] <= neg_s1[i];
				sq_s3[i] <= 60'(m_s2[i]) * 60'(m_s2[i]);
				m_s3[i] <= m_s2[i];
				neg_s3[i] <= neg_s2[i];
			end
			srem_s[0] <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
			sroot_s[0] <= '0;
			sm_s[0] <= m_s3;
			sneg_s[0] <= neg_s3;
		end
	end

	// floor square root, one root bit per stage
	for (genvar j = 0; j < RB; j++) begin : g_sqrt
		localparam int B = RB - 1 - j;
		logic [63:0] t;
		assign t = (64'(sroot_s[j]) << (B + 1)) + (64'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (srem_s[j] >= t) begin
					srem_s[j+1] <= srem_s[j] - t;
					sroot_s[j+1] <= sroot_s[j] | (31'd1 << B);
				end else begin
					srem_s[j+1] <= srem_s[j];
					sroot_s[j+1] <= sroot_s[j];
				end
				sm_s[j+1] <= sm_s[j];
				sneg_s[j+1] <= sneg_s[j];
			end
		end
	end

	// rounded dividend
	always_ff @(posedge clk) begin
		if (en) begin
			dlen_s[0] <= sroot_s[RB];
			for (int i = 0; i < 3; i++) begin
				drem_s[0][i] <= (64'(sm_s[RB][i]) << 30) + 64'(sroot_s[RB] >> 1);
				dq_s[0][i] <= '0;
			end
			dneg_s[0] <= sneg_s[RB];
		end
	end

	// restoring divide, one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int B = QB - 1 - j;
		logic [63:0] t;
		assign t = 64'(dlen_s[j]) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (drem_s[j][i] >= t) begin
						drem_s[j+1][i] <= drem_s[j][i] - t;
						dq_s[j+1][i] <= dq_s[j][i] | (31'd1 << B);
					end else begin
						drem_s[j+1][i] <= drem_s[j][i];
						dq_s[j+1][i] <= dq_s[j][i];
					end
				end
				dlen_s[j+1] <= dlen_s[j];
				dneg_s[j+1] <= dneg_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				uo_s[i] <= dneg_s[QB][i] ? -$signed({1'b0, dq_s[QB][i]})
					: $signed({1'b0, dq_s[QB][i]});
			end
			pay_s[0] <= in_pay;
			for (int k = 1; k < LAT; k++) pay_s[k] <= pay_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < LAT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	assign u = uo_s;
	assign out_valid = vld_s[LAT-1];
	assign out_pay = pay_s[LAT-1];

endmodule

// File: hw/rtl/pfb_out.sv
// pfb_out: output holding register, splits one frame into result words
// depends on pfb_pkg
module pfb_out import pfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  frame_t       in_frame,
	output logic         take,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // comp_x, comp_y, comp_z, 3 zero bits
	output logic [2:0]   m_tuser,  // vector_kind, frame_valid
	output logic         m_tlast
);

	frame_t fr_q;
	logic   vld_q;
	kind_t  beat_q;
	vec47_t vec;
	logic   fin;

	always_comb begin
		case (beat_q)
			KIND_ORIGIN: vec = fr_q.org;
			KIND_XAXIS:  vec = fr_q.xa;
			KIND_YAXIS:  vec = fr_q.ya;
			KIND_NORMAL: vec = fr_q.nu;
			default:     vec = fr_q.org;
		endcase
		if (fr_q.bad) vec = '0;
	end

	assign m_tlast = fr_q.bad || (beat_q == KIND_NORMAL);
	assign fin = m_tvalid && m_tready && m_tlast;
	assign take = !vld_q || fin;
	assign m_tvalid = vld_q;
	assign m_tdata = {3'b000, vec};
	assign m_tuser = {!fr_q.bad, beat_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			beat_q <= KIND_ORIGIN;
		end else begin
			if (take) begin
				vld_q <= in_valid;
				beat_q <= KIND_ORIGIN;
			end else if (m_tready) begin
				beat_q <= kind_t'(beat_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) fr_q <= in_frame;
	end

`ifndef NO_ASSERTIONS
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[2]) |-> (m_tlast && m_tuser[1:0] == KIND_ORIGIN && m_tdata == '0))
		else $error("degenerate frame word malformed");
	a_last_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2] && m_tlast) |-> (m_tuser[1:0] == KIND_NORMAL))
		else $error("valid frame ended early");
	a_beat_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
		(m_tvalid && m_tuser[1:0] == 2'($past(m_tuser[1:0]) + 2'd1)))
		else $error("beat sequence broken");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_valid) |=> (m_tvalid && m_tuser[1:0] == KIND_ORIGIN))
		else $error("frame lost at hand-off");
`endif

endmodule

// File: hw/rtl/plane_frame_builder_core.sv
// plane_frame_builder_core: orthonormal frame from a plane point and normal
// depends on pfb_pkg, pfb_unit, pfb_out
//
// usage
//  s_t* carries one plane per word: point x, y, z then normal x, y, z, signed
//  with INPUT_FRAC_BITS fraction bits. m_t* returns q16.30 vectors: origin,
//  x axis, y axis, normal, tlast on the normal word; a degenerate plane gives
//  one all-zero word with frame_valid low and tlast high.
//  cfg_* writes min_length_squared, always ready; write it only while idle.
//  path: an accepted plane passes through three 68-stage normalizers
//  (31 square root and 31 divide stages each), 16 core stages and the
//  output register before m_tvalid goes high.
//  throughput: a word is accepted every cycle while the pipeline moves; the
//  result side drains 4 words per frame (1 for a degenerate one), so in
//  steady state the output words set the plane rate.
//  when m_tready is low the pipeline advances until its last stage holds a
//  plane, then freezes with s_tready low; nothing is dropped or repeated.
//  reset clears all valid bits and sets min_length_squared to 1.
module plane_frame_builder_core import pfb_pkg::*; #(
	parameter int INPUT_FRAC_BITS = DEF_INPUT_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // point x, y, z, normal x, y, z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,  // comp_x, comp_y, comp_z, 3 zero bits
	output logic [2:0]   m_tuser,  // vector_kind, frame_valid
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	localparam int SH = 2 * INPUT_FRAC_BITS - 32;

	function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int r);
		logic [63:0] m;
		logic [63:0] a;
		m = x[63] ? 64'(-x) : 64'(x);
		a = (m + (64'd1 << (r - 1))) >> r;
		return x[63] ? -$signed(a) : $signed(a);
	endfunction

	function automatic logic [63:0] sq33(input logic signed [32:0] x);
		logic [31:0] m;
		m = x[32] ? 32'(-x) : x[31:0];
		return 64'(m) * 64'(m);
	endfunction

	function automatic logic [30:0] mag32(input logic signed [31:0] x);
		logic signed [31:0] t;
		t = x[31] ? -x : x;
		return t[30:0];
	endfunction

	logic [31:0] min_len_sq_q;
	logic        en;
	logic        take;
	logic [63:0] lim;
	logic [63:0] thr60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_len_sq_q <= 32'd1;
		else if (cfg_valid) min_len_sq_q <= cfg_data;
	end

	assign cfg_ready = 1'b1;
	assign thr60 = 64'(min_len_sq_q) << 28;

	always_comb begin
		if (SH >= 0) lim = 64'(min_len_sq_q) << SH;
		else lim = 64'(min_len_sq_q) >> (-SH);
	end

	// normal check
	logic               valid_s1, valid_s2, valid_s3;
	logic signed [31:0] p_s1 [3], p_s2 [3], p_s3 [3];
	logic signed [31:0] n_s1 [3], n_s2 [3], n_s3 [3];
	logic [63:0]        sq_s2 [3];
	logic               bad_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= s_tdata[32*i +: 32];
				n_s1[i] <= s_tdata[96+32*i +: 32];
				sq_s2[i] <= sq33({n_s1[i][31], n_s1[i]});
			end
			p_s2 <= p_s1;
			n_s2 <= n_s1;
			p_s3 <= p_s2;
			n_s3 <= n_s2;
			bad_s3 <= (sq_s2[0] + sq_s2[1] + sq_s2[2]) <= lim;
		end
	end

	logic signed [32:0] nc [3];
	logic               nu_vld;
	logic signed [31:0] nuu [3];
	logic [96:0]        nu_pay;

	always_comb begin
		for (int i = 0; i < 3; i++) nc[i] = {n_s3[i][31], n_s3[i]};
	end

	pfb_unit #(.PW(97)) u_norm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s3), .c(nc),
		.in_pay({bad_s3, p_s3[2], p_s3[1], p_s3[0]}),
		.out_valid(nu_vld), .u(nuu), .out_pay(nu_pay)
	);

	// orientation, projected axis
	logic               valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic signed [31:0] p_s4 [3], p_s5 [3], p_s6 [3], p_s7 [3], p_s8 [3];
	logic signed [31:0] nu_s4 [3], nu_s5 [3], nu_s6 [3], nu_s7 [3], nu_s8 [3];
	logic               bad_s4, bad_s5, bad_s6, bad_s7, bad_s8;
	logic [1:0]         k_s4, k_s5;
	logic signed [63:0] pr_s5 [3];
	logic signed [32:0] proj_s6 [3], proj_s7 [3], proj_s8 [3];
	logic [63:0]        psq_s7 [3];
	logic [1:0]         k_c;
	logic [30:0]        nm [3];
	logic signed [31:0] nbig, nk;

	always_comb begin
		for (int i = 0; i < 3; i++) nm[i] = mag32(nuu[i]);
		nbig = nuu[0];
		if (nm[1] > nm[0]) begin
			nbig = nuu[1];
		end
		if (nm[2] > mag32(nbig)) begin
			nbig = nuu[2];
		end
		k_c = 2'd0;
		if (nm[1] < nm[0]) k_c = 2'd1;
		if (nm[2] < ((k_c == 2'd1) ? nm[1] : nm[0])) k_c = 2'd2;
		case (k_s4)
			2'd0:    nk = nu_s4[0];
			2'd1:    nk = nu_s4[1];
			default: nk = nu_s4[2];
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s4[i] <= nu_pay[32*i +: 32];
				nu_s4[i] <= nbig[31] ? -nuu[i] : nuu[i];
				pr_s5[i] <= 64'(nu_s4[i]) * 64'(nk);
				proj_s6[i] <= 33'(((k_s5 == 2'(i)) ? Q30_ONE : 64'sd0) - rshr(pr_s5[i], 30));
				psq_s7[i] <= sq33(proj_s6[i]);
			end
			bad_s4 <= nu_pay[96];
			k_s4 <= k_c;
			k_s5 <= k_s4;
			p_s5 <= p_s4; p_s6 <= p_s5; p_s7 <= p_s6; p_s8 <= p_s7;
			nu_s5 <= nu_s4; nu_s6 <= nu_s5; nu_s7 <= nu_s6; nu_s8 <= nu_s7;
			bad_s5 <= bad_s4; bad_s6 <= bad_s5; bad_s7 <= bad_s6;
			proj_s7 <= proj_s6;
			proj_s8 <= proj_s7;
			bad_s8 <= bad_s7 || ((psq_s7[0] + psq_s7[1] + psq_s7[2]) <= thr60);
		end
	end

	logic               xa_vld;
	logic signed [31:0] xau [3];
	logic [192:0]       xa_pay;

	pfb_unit #(.PW(193)) u_xaxis (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s8), .c(proj_s8),
		.in_pay({bad_s8, nu_s8[2], nu_s8[1], nu_s8[0], p_s8[2], p_s8[1], p_s8[0]}),
		.out_valid(xa_vld), .u(xau), .out_pay(xa_pay)
	);

	// cross product
	logic               valid_s9, valid_s10, valid_s11, valid_s12;
	logic signed [31:0] p_s9 [3], p_s10 [3], p_s11 [3], p_s12 [3];
	logic signed [31:0] nu_s9 [3], nu_s10 [3], nu_s11 [3], nu_s12 [3];
	logic signed [31:0] xa_s9 [3], xa_s10 [3], xa_s11 [3], xa_s12 [3];
	logic               bad_s9, bad_s10, bad_s11, bad_s12;
	logic signed [63:0] cp_s9 [6];
	logic signed [32:0] cr_s10 [3], cr_s11 [3], cr_s12 [3];
	logic [63:0]        csq_s11 [3];
	logic signed [31:0] nx [3];

	always_comb begin
		for (int i = 0; i < 3; i++) nx[i] = xa_pay[96+32*i +: 32];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s9[i] <= xa_pay[32*i +: 32];
				csq_s11[i] <= sq33(cr_s10[i]);
			end
			nu_s9 <= nx;
			xa_s9 <= xau;
			bad_s9 <= xa_pay[192];
			cp_s9[0] <= 64'(nx[1]) * 64'(xau[2]);
			cp_s9[1] <= 64'(nx[2]) * 64'(xau[1]);
			cp_s9[2] <= 64'(nx[2]) * 64'(xau[0]);
			cp_s9[3] <= 64'(nx[0]) * 64'(xau[2]);
			cp_s9[4] <= 64'(nx[0]) * 64'(xau[1]);
			cp_s9[5] <= 64'(nx[1]) * 64'(xau[0]);
			cr_s10[0] <= 33'(rshr(cp_s9[0] - cp_s9[1], 30));
			cr_s10[1] <= 33'(rshr(cp_s9[2] - cp_s9[3], 30));
			cr_s10[2] <= 33'(rshr(cp_s9[4] - cp_s9[5], 30));
			p_s10 <= p_s9; p_s11 <= p_s10; p_s12 <= p_s11;
			nu_s10 <= nu_s9; nu_s11 <= nu_s10; nu_s12 <= nu_s11;
			xa_s10 <= xa_s9; xa_s11 <= xa_s10; xa_s12 <= xa_s11;
			bad_s10 <= bad_s9; bad_s11 <= bad_s10;
			cr_s11 <= cr_s10;
			cr_s12 <= cr_s11;
			bad_s12 <= bad_s11 || ((csq_s11[0] + csq_s11[1] + csq_s11[2]) <= thr60);
		end
	end

	logic               ya_vld;
	logic signed [31:0] yau [3];
	logic [288:0]       ya_pay;

	pfb_unit #(.PW(289)) u_yaxis (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s12), .c(cr_s12),
		.in_pay({bad_s12, xa_s12[2], xa_s12[1], xa_s12[0],
			nu_s12[2], nu_s12[1], nu_s12[0], p_s12[2], p_s12[1], p_s12[0]}),
		.out_valid(ya_vld), .u(yau), .out_pay(ya_pay)
	);

	// origin
	logic               valid_s13, valid_s14, valid_s15, valid_s16;
	logic signed [31:0] nu_s13 [3], nu_s14 [3], nu_s15 [3], nu_s16 [3];
	logic signed [31:0] xa_s13 [3], xa_s14 [3], xa_s15 [3], xa_s16 [3];
	logic signed [31:0] ya_s13 [3], ya_s14 [3], ya_s15 [3], ya_s16 [3];
	logic               bad_s13, bad_s14, bad_s15, bad_s16;
	logic signed [63:0] dp_s13 [3];
	logic signed [34:0] df_s14;
	logic signed [63:0] op_s15 [3];
	logic signed [46:0] org_s16 [3];
	logic signed [63:0] orr [3];
	logic signed [31:0] yn [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			yn[i] = ya_pay[96+32*i +: 32];
			orr[i] = rshr(op_s15[i], INPUT_FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dp_s13[i] <= 64'($signed(ya_pay[32*i +: 32])) * 64'(yn[i]);
				xa_s13[i] <= ya_pay[192+32*i +: 32];
				op_s15[i] <= 64'(df_s14) * 64'(nu_s14[i]);
				if (orr[i] > COMP_MAX) org_s16[i] <= COMP_MAX[46:0];
				else if (orr[i] < COMP_MIN) org_s16[i] <= COMP_MIN[46:0];
				else org_s16[i] <= orr[i][46:0];
			end
			nu_s13 <= yn;
			ya_s13 <= yau;
			bad_s13 <= ya_pay[288];
			df_s14 <= 35'(rshr(dp_s13[0] + dp_s13[1] + dp_s13[2], 30));
			nu_s14 <= nu_s13; nu_s15 <= nu_s14; nu_s16 <= nu_s15;
			xa_s14 <= xa_s13; xa_s15 <= xa_s14; xa_s16 <= xa_s15;
			ya_s14 <= ya_s13; ya_s15 <= ya_s14; ya_s16 <= ya_s15;
			bad_s14 <= bad_s13; bad_s15 <= bad_s14; bad_s16 <= bad_s15;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0; valid_s2 <= 1'b0; valid_s3 <= 1'b0;
			valid_s4 <= 1'b0; valid_s5 <= 1'b0; valid_s6 <= 1'b0;
			valid_s7 <= 1'b0; valid_s8 <= 1'b0; valid_s9 <= 1'b0;
			valid_s10 <= 1'b0; valid_s11 <= 1'b0; valid_s12 <= 1'b0;
			valid_s13 <= 1'b0; valid_s14 <= 1'b0; valid_s15 <= 1'b0;
			valid_s16 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid; valid_s2 <= valid_s1; valid_s3 <= valid_s2;
			valid_s4 <= nu_vld; valid_s5 <= valid_s4; valid_s6 <= valid_s5;
			valid_s7 <= valid_s6; valid_s8 <= valid_s7;
			valid_s9 <= xa_vld; valid_s10 <= valid_s9; valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= ya_vld; valid_s14 <= valid_s13; valid_s15 <= valid_s14;
			valid_s16 <= valid_s15;
		end
	end

	assign en = !valid_s16 || take;
	assign s_tready = en;

	frame_t fr;

	always_comb begin
		fr.bad = bad_s16;
		fr.org = {org_s16[2], org_s16[1], org_s16[0]};
		fr.xa = {47'(xa_s16[2]), 47'(xa_s16[1]), 47'(xa_s16[0])};
		fr.ya = {47'(ya_s16[2]), 47'(ya_s16[1]), 47'(ya_s16[0])};
		fr.nu = {47'(nu_s16[2]), 47'(nu_s16[1]), 47'(nu_s16[0])};
	end

	pfb_out u_out (
		.clk(clk), .arst_n(arst_n),
		.in_valid(valid_s16), .in_frame(fr), .take(take),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule
